>>> hw/rtl/modexp_pkg.sv
// modexp_pkg: widths, microcode encodings and the control program for the
// modular exponentiation block. No dependencies.
`default_nettype none

package modexp_pkg;

  localparam int EXP_BITS  = 63;
  localparam int BASE_W    = 63;
  localparam int MOD_W     = 32;
  localparam int PROD_W    = 2 * MOD_W;
  localparam int BITCNT_W  = $clog2(EXP_BITS + 1);
  localparam int DIV_CNT_W = $clog2(PROD_W + 1);
  localparam int STEP_W    = 5;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_DIV_BASE,
    OP_SET_B,
    OP_INIT_R,
    OP_MUL_RR,
    OP_MUL_RB,
    OP_DIV_PROD,
    OP_SET_R,
    OP_NEXT_BIT,
    OP_OUT_R,
    OP_OUT_ONE,
    OP_OUT_BAD
  } dp_op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_MOD_ZERO,
    C_EXP_ZERO,
    C_DIV_BUSY,
    C_BIT_CLEAR,
    C_MORE_BITS,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    step_t  target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic mod_zero;
    logic exp_zero;
    logic div_busy;
    logic bit_set;
    logic more_bits;
    logic out_full;
  } dp_status_t;

  localparam step_t ST_ACCEPT   = 5'd0;
  localparam step_t ST_CHK_MOD  = 5'd1;
  localparam step_t ST_CHK_EXP  = 5'd2;
  localparam step_t ST_RED_BASE = 5'd3;
  localparam step_t ST_SET_B    = 5'd4;
  localparam step_t ST_INIT_R   = 5'd5;
  localparam step_t ST_SQUARE   = 5'd6;
  localparam step_t ST_SQ_DIV   = 5'd7;
  localparam step_t ST_SQ_SET   = 5'd8;
  localparam step_t ST_TEST_BIT = 5'd9;
  localparam step_t ST_MULT     = 5'd10;
  localparam step_t ST_MUL_DIV  = 5'd11;
  localparam step_t ST_MUL_SET  = 5'd12;
  localparam step_t ST_NEXT_BIT = 5'd13;
  localparam step_t ST_WAIT_R   = 5'd14;
  localparam step_t ST_OUT_R    = 5'd15;
  localparam step_t ST_WAIT_ONE = 5'd16;
  localparam step_t ST_OUT_ONE  = 5'd17;
  localparam step_t ST_WAIT_BAD = 5'd18;
  localparam step_t ST_OUT_BAD  = 5'd19;
  localparam int    PROG_LEN    = 20;

  // jump to target when the condition holds, else fall through to the next step
  function automatic ctrl_word_t ucode_rom(input step_t s);
    ctrl_word_t w;
    case (s)
      ST_ACCEPT:   w = '{OP_ACCEPT,   C_NO_INPUT,  ST_ACCEPT};
      ST_CHK_MOD:  w = '{OP_NOP,      C_MOD_ZERO,  ST_WAIT_BAD};
      ST_CHK_EXP:  w = '{OP_NOP,      C_EXP_ZERO,  ST_WAIT_ONE};
      ST_RED_BASE: w = '{OP_DIV_BASE, C_NEVER,     ST_ACCEPT};
      ST_SET_B:    w = '{OP_SET_B,    C_DIV_BUSY,  ST_SET_B};
      ST_INIT_R:   w = '{OP_INIT_R,   C_NEVER,     ST_ACCEPT};
      ST_SQUARE:   w = '{OP_MUL_RR,   C_NEVER,     ST_ACCEPT};
      ST_SQ_DIV:   w = '{OP_DIV_PROD, C_NEVER,     ST_ACCEPT};
      ST_SQ_SET:   w = '{OP_SET_R,    C_DIV_BUSY,  ST_SQ_SET};
      ST_TEST_BIT: w = '{OP_NOP,      C_BIT_CLEAR, ST_NEXT_BIT};
      ST_MULT:     w = '{OP_MUL_RB,   C_NEVER,     ST_ACCEPT};
      ST_MUL_DIV:  w = '{OP_DIV_PROD, C_NEVER,     ST_ACCEPT};
      ST_MUL_SET:  w = '{OP_SET_R,    C_DIV_BUSY,  ST_MUL_SET};
      ST_NEXT_BIT: w = '{OP_NEXT_BIT, C_MORE_BITS, ST_SQUARE};
      ST_WAIT_R:   w = '{OP_NOP,      C_OUT_FULL,  ST_WAIT_R};
      ST_OUT_R:    w = '{OP_OUT_R,    C_ALWAYS,    ST_ACCEPT};
      ST_WAIT_ONE: w = '{OP_NOP,      C_OUT_FULL,  ST_WAIT_ONE};
      ST_OUT_ONE:  w = '{OP_OUT_ONE,  C_ALWAYS,    ST_ACCEPT};
      ST_WAIT_BAD: w = '{OP_NOP,      C_OUT_FULL,  ST_WAIT_BAD};
      ST_OUT_BAD:  w = '{OP_OUT_BAD,  C_ALWAYS,    ST_ACCEPT};
      default:     w = '{OP_NOP,      C_ALWAYS,    ST_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/modexp_if.sv
// modexp_in_if and modexp_out_if: valid/ready channels for operands and results.
// Depends on modexp_pkg.
`default_nettype none

interface modexp_in_if import modexp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BASE_W-1:0] base;
  logic [BASE_W-1:0] exponent;
  logic [MOD_W-1:0]  modulus;

  modport source (output valid, base, exponent, modulus, input ready);
  modport sink (input valid, base, exponent, modulus, output ready);
endinterface

interface modexp_out_if import modexp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MOD_W-1:0] residue;
  logic             bad_modulus;

  modport source (output valid, residue, bad_modulus, input ready);
  modport sink (input valid, residue, bad_modulus, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/modexp_div.sv
// modexp_div: bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on modexp_pkg.
`default_nettype none

module modexp_div import modexp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] dividend,
  input  wire logic [MOD_W-1:0]  divisor,
  output logic                   busy,
  output logic [MOD_W-1:0]       rem
);

  logic [PROD_W-1:0]    dvd;
  logic [DIV_CNT_W-1:0] cnt;
  logic [MOD_W:0]       trial;
  logic [MOD_W:0]       diff;

  assign trial = {rem, dvd[PROD_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == DIV_CNT_W'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      cnt <= DIV_CNT_W'(PROD_W);
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= diff[MOD_W] ? trial[MOD_W-1:0] : diff[MOD_W-1:0];
      cnt <= cnt - 1'b1;
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("remainder unit restarted while busy");
  a_rem_below: assert property (@(posedge clk) disable iff (rst) busy |-> rem < divisor)
    else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

>>> hw/rtl/modexp_dp.sv
// modexp_dp: operand, running value and product registers, output register.
// Depends on modexp_pkg, modexp_if and modexp_div.
`default_nettype none

module modexp_dp import modexp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire dp_op_t   op,
  output dp_status_t    status,
  modexp_in_if.sink     operands,
  modexp_out_if.source  result
);

  logic [BASE_W-1:0]   base_reg;
  logic [EXP_BITS-1:0] exp_reg;
  logic [BITCNT_W-1:0] bit_cnt;
  logic [MOD_W-1:0]    m;
  logic [MOD_W-1:0]    b;
  logic [MOD_W-1:0]    r;
  logic [PROD_W-1:0]   prod;
  logic [MOD_W-1:0]    residue;
  logic                bad_modulus;
  logic                out_valid;
  logic                div_start;
  logic                div_busy;
  logic [PROD_W-1:0]   div_dividend;
  logic [MOD_W-1:0]    div_rem;

  assign div_start    = (op == OP_DIV_BASE) || (op == OP_DIV_PROD);
  assign div_dividend = (op == OP_DIV_BASE) ? PROD_W'(base_reg) : prod;

  modexp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (m),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  assign operands.ready     = (op == OP_ACCEPT);
  assign result.valid       = out_valid;
  assign result.residue     = residue;
  assign result.bad_modulus = bad_modulus;

  assign status.in_valid  = operands.valid;
  assign status.mod_zero  = (m == '0);
  assign status.exp_zero  = (exp_reg == '0);
  assign status.div_busy  = div_busy;
  assign status.bit_set   = exp_reg[EXP_BITS-1];
  assign status.more_bits = (bit_cnt != '0);
  assign status.out_full  = out_valid && !result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_OUT_R || op == OP_OUT_ONE || op == OP_OUT_BAD) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_ACCEPT: begin
        if (operands.valid) begin
          base_reg <= operands.base;
          exp_reg  <= operands.exponent[EXP_BITS-1:0];
          m        <= operands.modulus;
          bit_cnt  <= BITCNT_W'(EXP_BITS - 1);
        end
      end
      OP_SET_B: begin
        if (!div_busy) begin
          b <= div_rem;
        end
      end
      OP_INIT_R: r <= (m == MOD_W'(1)) ? '0 : MOD_W'(1);
      OP_MUL_RR: prod <= PROD_W'(r) * PROD_W'(r);
      OP_MUL_RB: prod <= PROD_W'(r) * PROD_W'(b);
      OP_SET_R: begin
        if (!div_busy) begin
          r <= div_rem;
        end
      end
      OP_NEXT_BIT: begin
        exp_reg <= exp_reg << 1;
        bit_cnt <= bit_cnt - 1'b1;
      end
      OP_OUT_R: begin
        residue     <= r;
        bad_modulus <= 1'b0;
      end
      OP_OUT_ONE: begin
        residue     <= MOD_W'(1);
        bad_modulus <= 1'b0;
      end
      OP_OUT_BAD: begin
        residue     <= '0;
        bad_modulus <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (op == OP_OUT_R || op == OP_OUT_ONE || op == OP_OUT_BAD) |-> !out_valid)
    else $error("output register loaded while occupied");
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    (op == OP_MUL_RR || op == OP_MUL_RB) |-> (r < m && b < m))
    else $error("multiplier operand not reduced");

endmodule

`default_nettype wire

>>> hw/rtl/modexp_seq.sv
// modexp_seq: step counter over the microcode program with conditional jumps.
// Depends on modexp_pkg.
`default_nettype none

module modexp_seq import modexp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire dp_status_t status,
  output dp_op_t          op
);

  step_t      step;
  step_t      step_next;
  ctrl_word_t cw;
  logic       take;

  always_comb begin
    cw = ucode_rom(step);
    case (cw.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_INPUT:  take = !status.in_valid;
      C_MOD_ZERO:  take = status.mod_zero;
      C_EXP_ZERO:  take = status.exp_zero;
      C_DIV_BUSY:  take = status.div_busy;
      C_BIT_CLEAR: take = !status.bit_set;
      C_MORE_BITS: take = status.more_bits;
      C_OUT_FULL:  take = status.out_full;
      default:     take = 1'b1;
    endcase
    step_next = take ? cw.target : step + 1'b1;
  end

  assign op = cw.op;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_ACCEPT;
    end else begin
      step <= step_next;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    32'(step) < PROG_LEN)
    else $error("step counter left the program");

endmodule

`default_nettype wire

>>> hw/rtl/modular_exponentiation.sv
// modular_exponentiation: top level, base^exponent mod modulus by square-and-multiply.
// Depends on modexp_pkg, modexp_if, modexp_seq and modexp_dp.
// One item at a time: operands are taken in the sequencer's accept step, the
// exponent is scanned from bit EXP_BITS-1 down, each square and each multiply
// is a registered 32x32 product followed by the bit-serial remainder unit that
// retires one dividend bit per cycle. A zero modulus returns residue 0 with
// bad_modulus set; a zero exponent returns 1. The output register lets the
// next item be accepted while a result waits.
`default_nettype none

module modular_exponentiation import modexp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  modexp_in_if.sink    operands,
  modexp_out_if.source result
);

  dp_op_t     op;
  dp_status_t status;

  modexp_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  modexp_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .status   (status),
    .operands (operands),
    .result   (result)
  );

endmodule

`default_nettype wire

>>> sim/tb_modular_exponentiation.sv
// tb_modular_exponentiation: self-checking bench for modular_exponentiation, directed
// vectors then random operands under several idle and stall mixes, with an internal predictor.
// Depends on modexp_pkg, modexp_if and the modular_exponentiation RTL.
`default_nettype none

module tb_modular_exponentiation import modexp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PER_PHASE = 20;
  localparam int CYCLE_LIMIT      = 4_000_000;
  localparam int DRAIN_CYCLES     = 32;

  localparam logic [BASE_W-1:0] FIELD_MAX = '1;
  localparam logic [MOD_W-1:0]  MOD_MAX   = '1;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [BASE_W-1:0] exponent;
    logic [MOD_W-1:0]  modulus;
  } operand_t;

  typedef struct packed {
    logic [MOD_W-1:0] residue;
    logic             bad_modulus;
  } residue_t;

  typedef struct packed {
    operand_t op;
    logic     known;
    residue_t want;
  } vector_t;

  localparam int N_DIRECTED = 18;

  vector_t directed [N_DIRECTED] = '{
    '{'{FIELD_MAX, FIELD_MAX, 32'd0}, 1'b1, '{32'd0, 1'b1}},
    '{'{63'd0, 63'd0, 32'd0}, 1'b1, '{32'd0, 1'b1}},
    '{'{63'd5, 63'd0, 32'd7}, 1'b1, '{32'd1, 1'b0}},
    '{'{63'd5, 63'd0, 32'd1}, 1'b1, '{32'd1, 1'b0}},
    '{'{FIELD_MAX, 63'd0, MOD_MAX}, 1'b1, '{32'd1, 1'b0}},
    '{'{63'd12345, 63'd1, 32'd1}, 1'b1, '{32'd0, 1'b0}},
    '{'{FIELD_MAX, FIELD_MAX, 32'd1}, 1'b1, '{32'd0, 1'b0}},
    '{'{63'd0, 63'd5, 32'd13}, 1'b1, '{32'd0, 1'b0}},
    '{'{63'd1, FIELD_MAX, MOD_MAX}, 1'b1, '{32'd1, 1'b0}},
    '{'{63'd2, 63'd10, 32'd1000}, 1'b1, '{32'd24, 1'b0}},
    '{'{63'd7, 63'd1, 32'd2}, 1'b1, '{32'd1, 1'b0}},
    '{'{FIELD_MAX, FIELD_MAX, MOD_MAX}, 1'b0, '0},
    '{'{FIELD_MAX, 63'd1, MOD_MAX}, 1'b0, '0},
    '{'{63'd3, 63'h4000_0000_0000_0000, 32'hFFFF_FFFB}, 1'b0, '0},
    '{'{63'h0000_0000_FFFF_FFFE, 63'd2, MOD_MAX}, 1'b0, '0},
    '{'{63'h0000_0001_0000_0000, 63'd3, 32'h8000_0000}, 1'b0, '0},
    '{'{63'h2AAA_5555_1234_ABCD, 63'h5555_AAAA_0F0F_F0F0, 32'h7FFF_FFFF}, 1'b0, '0},
    '{'{63'd123456789, FIELD_MAX, 32'd65537}, 1'b0, '0}
  };

  int src_pct [4] = '{0, 59, 0, 29};
  int snk_pct [4] = '{0, 0, 59, 29};

  logic clk;
  logic rst;

  modexp_in_if  opnd_ch ();
  modexp_out_if res_ch ();

  modular_exponentiation dut (
    .clk      (clk),
    .rst      (rst),
    .operands (opnd_ch.sink),
    .result   (res_ch.source)
  );

  residue_t pending_residues [$];
  residue_t seen_want;
  int       mismatches = 0;
  int       src_idle_pct;
  int       snk_stall_pct;
  int       cycles = 0;

  function automatic residue_t power_mod(input operand_t op);
    residue_t    res;
    logic [63:0] m;
    logic [63:0] b;
    logic [63:0] r;
    res = '0;
    m = 64'(op.modulus);
    if (m == 64'd0) begin
      res.bad_modulus = 1'b1;
    end else if (op.exponent == '0) begin
      res.residue = 32'd1;
    end else begin
      b = 64'(op.base) % m;
      r = 64'd1 % m;
      for (int i = EXP_BITS - 1; i >= 0; i--) begin
        r = (r * r) % m;
        if (op.exponent[i]) begin
          r = (r * b) % m;
        end
      end
      res.residue = r[MOD_W-1:0];
    end
    return res;
  endfunction

  function automatic operand_t random_operands();
    operand_t op;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      op.base = BASE_W'($urandom_range(0, 20));
    end else begin
      op.base = BASE_W'({$urandom, $urandom});
    end
    pick = $urandom_range(99);
    if (pick < 6) begin
      op.exponent = '0;
    end else if (pick < 20) begin
      op.exponent = BASE_W'($urandom_range(1, 64));
    end else begin
      op.exponent = BASE_W'({$urandom, $urandom});
    end
    pick = $urandom_range(99);
    if (pick < 6) begin
      op.modulus = '0;
    end else if (pick < 12) begin
      op.modulus = MOD_W'($urandom_range(1, 3));
    end else if (pick < 18) begin
      op.modulus = MOD_MAX;
    end else begin
      op.modulus = $urandom;
    end
    return op;
  endfunction

  task automatic send_operands(input operand_t op, input residue_t want);
    if ($urandom_range(99) < src_idle_pct) begin
      opnd_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    opnd_ch.valid    <= 1'b1;
    opnd_ch.base     <= op.base;
    opnd_ch.exponent <= op.exponent;
    opnd_ch.modulus  <= op.modulus;
    do @(posedge clk); while (!opnd_ch.ready);
    pending_residues.insert(pending_residues.size(), want);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_residues.size() == 0) begin
        $display("%0t: unexpected transfer, residue %h bad_modulus %b", $time,
                 res_ch.residue, res_ch.bad_modulus);
        mismatches++;
      end else begin
        seen_want = pending_residues.pop_front();
        if (res_ch.residue !== seen_want.residue) begin
          $display("%0t: residue expected %h, got %h", $time, seen_want.residue,
                   res_ch.residue);
          mismatches++;
        end
        if (res_ch.bad_modulus !== seen_want.bad_modulus) begin
          $display("%0t: bad_modulus expected %b, got %b", $time, seen_want.bad_modulus,
                   res_ch.bad_modulus);
          mismatches++;
        end
      end
    end
    res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d transfers outstanding", $time, pending_residues.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    operand_t op;
    residue_t want;
    rst              = 1'b1;
    opnd_ch.valid    = 1'b0;
    opnd_ch.base     = '0;
    opnd_ch.exponent = '0;
    opnd_ch.modulus  = '0;
    src_idle_pct     = 0;
    snk_stall_pct    = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      op = directed[i].op;
      want = directed[i].known ? directed[i].want : power_mod(op);
      send_operands(op, want);
    end

    for (int phase = 0; phase < 4; phase++) begin
      src_idle_pct  = src_pct[phase];
      snk_stall_pct = snk_pct[phase];
      repeat (RANDOM_PER_PHASE) begin
        op = random_operands();
        send_operands(op, power_mod(op));
      end
    end
    opnd_ch.valid <= 1'b0;

    while (pending_residues.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
